### src/cir_pkg.sv
package cir_pkg;

    // Port field widths
    localparam int VEL_W = 32;
    localparam int IM_W  = 31;
    localparam int NRM_W = 18;
    localparam int CO_W  = 18;
    localparam int OUT_W = 32;

    // Impulse magnitudes (normal, tangential, dynamic friction) clamp here
    localparam int J_W = 38;
    localparam logic [J_W-1:0] J_MAX = {J_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_ZERO     = 2'd1,
        ACT_NORMAL   = 2'd2,
        ACT_FRICTION = 2'd3
    } action_t;

endpackage

### src/cir_delay.sv
// Enabled shift line; D == 0 is a plain wire.
module cir_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    generate
        if (D == 0)
        begin : g_wire
            assign q = d;
        end
        else
        begin : g_line
            logic [W-1:0] line_reg [D];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    line_reg[0] <= d;
                    for (int i = 1; i < D; i++)
                    begin
                        line_reg[i] <= line_reg[i-1];
                    end
                end
            end

            assign q = line_reg[D-1];
        end
    endgenerate

endmodule

### src/cir_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module cir_div #(
    parameter int NW = 8,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] nq_reg  [NW];
    logic [DW-1:0] den_reg [NW];

    genvar k;
    generate
        for (k = 0; k < NW; k++)
        begin : g_stage
            logic [DW-1:0] rem_prev;
            logic [NW-1:0] nq_prev;
            logic [DW-1:0] den_prev;
            logic [DW:0]   cur;
            logic [DW:0]   diff;
            logic          take;

            if (k == 0)
            begin : g_first
                assign rem_prev = '0;
                assign nq_prev  = num;
                assign den_prev = den;
            end
            else
            begin : g_next
                assign rem_prev = rem_reg[k-1];
                assign nq_prev  = nq_reg[k-1];
                assign den_prev = den_reg[k-1];
            end

            assign cur  = {rem_prev, nq_prev[NW-1]};
            assign diff = cur - {1'b0, den_prev};
            assign take = (cur >= {1'b0, den_prev});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? diff[DW-1:0] : cur[DW-1:0];
                    nq_reg[k]  <= {nq_prev[NW-2:0], take};
                    den_reg[k] <= den_prev;
                end
            end
        end
    endgenerate

    assign quo = nq_reg[NW-1];

endmodule

### src/cir_sqrt.sv
// Pipelined integer square root (floor), one root bit per stage.
module cir_sqrt #(
    parameter int IW = 8
) (
    input  logic            clk,
    input  logic            en,
    input  logic [IW-1:0]   x,
    output logic [IW/2-1:0] root
);

    localparam int RT_W = IW / 2;
    localparam int RM_W = RT_W + 3;

    logic [RM_W-1:0] rem_reg  [RT_W];
    logic [RT_W-1:0] root_reg [RT_W];
    logic [IW-1:0]   rest_reg [RT_W];

    genvar k;
    generate
        for (k = 0; k < RT_W; k++)
        begin : g_stage
            logic [RM_W-1:0] rem_prev;
            logic [RT_W-1:0] root_prev;
            logic [IW-1:0]   rest_prev;
            logic [RM_W-1:0] cur;
            logic [RM_W-1:0] trial;
            logic            take;

            if (k == 0)
            begin : g_first
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign rest_prev = x;
            end
            else
            begin : g_next
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign rest_prev = rest_reg[k-1];
            end

            assign cur   = {rem_prev[RM_W-3:0], rest_prev[IW-1:IW-2]};
            assign trial = {1'b0, root_prev, 2'b01};
            assign take  = (cur >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= take ? (cur - trial) : cur;
                    root_reg[k] <= {root_prev[RT_W-2:0], take};
                    rest_reg[k] <= {rest_prev[IW-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign root = root_reg[RT_W-1];

endmodule

### src/contact_impulse_with_friction.sv
// 2D contact impulse with Coulomb friction, fixed point with FRAC_BITS fraction bits.
//
// Input channel item_valid/item_ready carries one contact per transfer: body
// velocities, inverse masses, unit normal (A to B), restitution and the static
// and dynamic friction coefficients. Output channel result_valid/result_ready
// carries action and the saturated impulse on B (A takes the negation).
//
// Fully pipelined, no state between contacts: one transfer per cycle in and out
// while the output is not stalled. Values are Q16.16 at the default FRAC_BITS. The
// pipe depth is set by the serial chain of the normal-velocity front end, the square
// root of the tangent length, the tangent normalizing divider and the tangential
// impulse divider, each one quotient or root bit per stage.
//
// Reset clears all valid bits; no result is presented until a contact arrives.
// When the receiver holds result_ready low with a result waiting, the whole pipe
// freezes; the entry stage still takes one more contact if it is empty.
module contact_impulse_with_friction #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic signed [cir_pkg::VEL_W-1:0]  vel_a_x,
    input  logic signed [cir_pkg::VEL_W-1:0]  vel_a_y,
    input  logic signed [cir_pkg::VEL_W-1:0]  vel_b_x,
    input  logic signed [cir_pkg::VEL_W-1:0]  vel_b_y,
    input  logic        [cir_pkg::IM_W-1:0]   inv_mass_a,
    input  logic        [cir_pkg::IM_W-1:0]   inv_mass_b,
    input  logic signed [cir_pkg::NRM_W-1:0]  normal_x,
    input  logic signed [cir_pkg::NRM_W-1:0]  normal_y,
    input  logic        [cir_pkg::CO_W-1:0]   bounce,
    input  logic        [cir_pkg::CO_W-1:0]   stick_coeff,
    input  logic        [cir_pkg::CO_W-1:0]   slide_coeff,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic        [1:0]                 action,
    output logic signed [cir_pkg::OUT_W-1:0]  impulse_x,
    output logic signed [cir_pkg::OUT_W-1:0]  impulse_y
);

    localparam int F     = FRAC_BITS;
    localparam int NRM_W = cir_pkg::NRM_W;
    localparam int CO_W  = cir_pkg::CO_W;
    localparam int J_W   = cir_pkg::J_W;
    localparam int OUT_W = cir_pkg::OUT_W;
    localparam int RND_W = 96;

    // datapath widths
    localparam int RV_W  = cir_pkg::VEL_W + 1;              // relative velocity
    localparam int IMS_W = cir_pkg::IM_W + 1;               // inverse-mass sum
    localparam int PN1_W = RV_W + NRM_W;
    localparam int VN_W  = PN1_W + 1;                       // vn, 2F fraction bits
    localparam int VNQ_W = VN_W - F + 1;
    localparam int OE_W  = ((F > CO_W) ? F : CO_W) + 1;     // ONE + e
    localparam int NJ_W  = VNQ_W + OE_W;                    // normal impulse numerator
    localparam int PN_W  = NRM_W + VNQ_W;
    localparam int PNR_W = PN_W - F + 1;
    localparam int TX_W  = ((PNR_W > RV_W) ? PNR_W : RV_W) + 1;
    localparam int LB_W  = $clog2(TX_W + 1);
    localparam int AX_W  = 30;                              // tangent after fitting
    localparam int SQ_W  = 2 * AX_W;
    localparam int SS_W  = SQ_W + 1;
    localparam int SI_W  = SS_W + 1;                        // even root input
    localparam int LEN_W = SI_W / 2;
    localparam int UN_W  = AX_W + F;
    localparam int UQ_W  = F + 1;
    localparam int UX_W  = UQ_W + 1;
    localparam int DP_W  = RV_W + UX_W;
    localparam int D_W   = DP_W + 1;
    localparam int JT_W  = J_W + 1;
    localparam int NJP_W = NRM_W + JT_W;
    localparam int INJ_W = NJP_W - F + 1;
    localparam int JM_W  = J_W + CO_W;
    localparam int LIM_W = JM_W + 1 - F;
    localparam int CMP_W = J_W + LIM_W;
    localparam int PF_W  = UX_W + JT_W;
    localparam int PFR_W = PF_W - F + 1;
    localparam int S_W   = ((INJ_W > PFR_W) ? INJ_W : PFR_W) + 1;

    // stage numbers (stage 1 is the entry register)
    localparam int S_SQ = 10 + LEN_W;           // tangent length ready
    localparam int S_P  = S_SQ + UN_W;          // unit tangent quotient ready
    localparam int S_D  = S_P + 4;              // |d| ready
    localparam int S_J  = 5 + NJ_W;             // normal impulse quotient ready
    localparam int S_A  = S_D + D_W + 1;        // jt ready, both branches meet
    localparam int NST  = S_A + 4;              // output register

    localparam logic [RND_W-1:0] HALF = RND_W'(1) << (F - 1);

    // sign-magnitude shift right by F, half away from zero
    function automatic logic signed [RND_W-1:0] rnd(input logic signed [RND_W-1:0] v);
        logic [RND_W-1:0] mag;
        logic [RND_W-1:0] m;
        mag = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
        m   = (mag + HALF) >> F;
        return v[RND_W-1] ? -$signed(m) : $signed(m);
    endfunction

    // ---------------- flow control ----------------
    logic [NST-1:0] vld_reg;
    logic           step;      // whole pipe advances
    logic           load_s1;   // entry stage takes a transfer

    assign step       = !vld_reg[NST-1] || result_ready;
    assign load_s1    = step || !vld_reg[0];
    assign item_ready = load_s1;
    assign result_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (load_s1)
            begin
                vld_reg[0] <= item_valid;
            end
            if (step)
            begin
                vld_reg[NST-1:1] <= vld_reg[NST-2:0];
            end
        end
    end

    // ---------------- stage 1: entry ----------------
    logic signed [RV_W-1:0]  s1_rx_reg, s1_ry_reg;
    logic        [IMS_W-1:0] s1_ims_reg;
    logic signed [NRM_W-1:0] s1_nx_reg, s1_ny_reg;
    logic        [CO_W-1:0]  s1_e_reg, s1_mus_reg, s1_mud_reg;
    logic                    s1_zero_reg;
    logic        [IMS_W-1:0] s1_ims_next;

    assign s1_ims_next = IMS_W'(inv_mass_a) + IMS_W'(inv_mass_b);

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_rx_reg   <= RV_W'(vel_b_x) - RV_W'(vel_a_x);
            s1_ry_reg   <= RV_W'(vel_b_y) - RV_W'(vel_a_y);
            s1_ims_reg  <= s1_ims_next;
            s1_nx_reg   <= normal_x;
            s1_ny_reg   <= normal_y;
            s1_e_reg    <= bounce;
            s1_mus_reg  <= stick_coeff;
            s1_mud_reg  <= slide_coeff;
            s1_zero_reg <= (s1_ims_next == '0);
        end
    end

    // ---------------- stages 2..5: normal velocity ----------------
    logic signed [PN1_W-1:0] s2_prx_next, s2_pry_next;
    logic signed [PN1_W-1:0] s2_prx_reg, s2_pry_reg;
    logic signed [VN_W-1:0]  s3_vn_reg;
    logic signed [VNQ_W-1:0] s4_vnq_reg;
    logic                    s4_sep_reg;
    logic signed [NRM_W-1:0] nx_4, ny_4;
    logic        [CO_W-1:0]  e_4;
    logic        [VNQ_W-1:0] s4_vmag;
    logic        [OE_W-1:0]  s4_oe;
    logic        [NJ_W-1:0]  s5_numj_next, s5_numj_reg;
    logic signed [PN_W-1:0]  s5_pnx_next, s5_pny_next;
    logic signed [PN_W-1:0]  s5_pnx_reg, s5_pny_reg;

    assign s2_prx_next = s1_rx_reg * s1_nx_reg;
    assign s2_pry_next = s1_ry_reg * s1_ny_reg;

    cir_delay #(.W(2 * NRM_W + CO_W), .D(3)) u_dly_n4 (
        .clk (clk),
        .en  (step),
        .d   ({s1_nx_reg, s1_ny_reg, s1_e_reg}),
        .q   ({nx_4, ny_4, e_4})
    );

    assign s4_vmag      = s4_vnq_reg[VNQ_W-1] ? VNQ_W'(-s4_vnq_reg) : VNQ_W'(s4_vnq_reg);
    assign s4_oe        = OE_W'(1 << F) + OE_W'(e_4);
    assign s5_numj_next = NJ_W'(s4_vmag) * NJ_W'(s4_oe);
    assign s5_pnx_next  = nx_4 * s4_vnq_reg;
    assign s5_pny_next  = ny_4 * s4_vnq_reg;

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            s2_prx_reg  <= s2_prx_next;
            s2_pry_reg  <= s2_pry_next;
            s3_vn_reg   <= VN_W'(s2_prx_reg) + VN_W'(s2_pry_reg);
            s4_vnq_reg  <= VNQ_W'(rnd(RND_W'(s3_vn_reg)));
            s4_sep_reg  <= !s3_vn_reg[VN_W-1] && (s3_vn_reg != '0);
            s5_numj_reg <= s5_numj_next;
            s5_pnx_reg  <= s5_pnx_next;
            s5_pny_reg  <= s5_pny_next;
        end
    end

    // ---------------- normal impulse j ----------------
    logic [IMS_W-1:0] ims_5;
    logic [NJ_W-1:0]  j_quo;
    logic [J_W-1:0]   sj_reg;
    logic [J_W-1:0]   j_a;

    cir_delay #(.W(IMS_W), .D(4)) u_dly_ims5 (
        .clk (clk),
        .en  (step),
        .d   (s1_ims_reg),
        .q   (ims_5)
    );

    cir_div #(.NW(NJ_W), .DW(IMS_W)) u_div_j (
        .clk (clk),
        .en  (step),
        .num (s5_numj_reg),
        .den (ims_5),
        .quo (j_quo)
    );

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            sj_reg <= (j_quo > NJ_W'(cir_pkg::J_MAX)) ? cir_pkg::J_MAX : j_quo[J_W-1:0];
        end
    end

    cir_delay #(.W(J_W), .D(S_A - S_J - 1)) u_dly_j (
        .clk (clk),
        .en  (step),
        .d   (sj_reg),
        .q   (j_a)
    );

    // ---------------- tangent and its length ----------------
    logic signed [RV_W-1:0]  rx_5, ry_5;
    logic signed [TX_W-1:0]  s6_tx_reg, s6_ty_reg;
    logic        [TX_W-1:0]  s7_ax_reg, s7_ay_reg;
    logic                    s7_sx_reg, s7_sy_reg;
    logic        [TX_W-1:0]  s7_or;
    logic        [LB_W-1:0]  s7_blen;
    logic        [LB_W-1:0]  s7_sh;
    logic        [AX_W-1:0]  s8_ax_reg, s8_ay_reg;
    logic        [SQ_W-1:0]  s9_sqx_reg, s9_sqy_reg;
    logic        [SS_W-1:0]  s10_ss_reg;
    logic        [LEN_W-1:0] len;
    logic                    len_nz_a;

    cir_delay #(.W(2 * RV_W), .D(4)) u_dly_r5 (
        .clk (clk),
        .en  (step),
        .d   ({s1_rx_reg, s1_ry_reg}),
        .q   ({rx_5, ry_5})
    );

    // shift both components right until each fits in AX_W bits
    assign s7_or = s7_ax_reg | s7_ay_reg;

    always_comb
    begin
        s7_blen = '0;
        for (int i = 0; i < TX_W; i++)
        begin
            if (s7_or[i])
            begin
                s7_blen = LB_W'(i + 1);
            end
        end
        s7_sh = (s7_blen > LB_W'(AX_W)) ? (s7_blen - LB_W'(AX_W)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            s6_tx_reg  <= TX_W'(rx_5) - TX_W'(PNR_W'(rnd(RND_W'(s5_pnx_reg))));
            s6_ty_reg  <= TX_W'(ry_5) - TX_W'(PNR_W'(rnd(RND_W'(s5_pny_reg))));
            s7_ax_reg  <= s6_tx_reg[TX_W-1] ? TX_W'(-s6_tx_reg) : TX_W'(s6_tx_reg);
            s7_ay_reg  <= s6_ty_reg[TX_W-1] ? TX_W'(-s6_ty_reg) : TX_W'(s6_ty_reg);
            s7_sx_reg  <= s6_tx_reg[TX_W-1];
            s7_sy_reg  <= s6_ty_reg[TX_W-1];
            s8_ax_reg  <= AX_W'(s7_ax_reg >> s7_sh);
            s8_ay_reg  <= AX_W'(s7_ay_reg >> s7_sh);
            s9_sqx_reg <= SQ_W'(s8_ax_reg) * SQ_W'(s8_ax_reg);
            s9_sqy_reg <= SQ_W'(s8_ay_reg) * SQ_W'(s8_ay_reg);
            s10_ss_reg <= SS_W'(s9_sqx_reg) + SS_W'(s9_sqy_reg);
        end
    end

    cir_sqrt #(.IW(SI_W)) u_sqrt (
        .clk  (clk),
        .en   (step),
        .x    ({1'b0, s10_ss_reg}),
        .root (len)
    );

    cir_delay #(.W(1), .D(S_A - S_SQ)) u_dly_lnz (
        .clk (clk),
        .en  (step),
        .d   (len != '0),
        .q   (len_nz_a)
    );

    // ---------------- unit tangent ----------------
    logic [AX_W-1:0]        ax_sq, ay_sq;
    logic                   sx_p, sy_p;
    logic [UN_W-1:0]        qux, quy;
    logic signed [UX_W-1:0] sp1_ux_reg, sp1_uy_reg;
    logic signed [UX_W-1:0] ux_t2, uy_t2;

    cir_delay #(.W(2 * AX_W), .D(S_SQ - 8)) u_dly_ax (
        .clk (clk),
        .en  (step),
        .d   ({s8_ax_reg, s8_ay_reg}),
        .q   ({ax_sq, ay_sq})
    );

    cir_delay #(.W(2), .D(S_P - 7)) u_dly_sgn (
        .clk (clk),
        .en  (step),
        .d   ({s7_sx_reg, s7_sy_reg}),
        .q   ({sx_p, sy_p})
    );

    cir_div #(.NW(UN_W), .DW(LEN_W)) u_div_ux (
        .clk (clk),
        .en  (step),
        .num ({ax_sq, {F{1'b0}}}),
        .den (len),
        .quo (qux)
    );

    cir_div #(.NW(UN_W), .DW(LEN_W)) u_div_uy (
        .clk (clk),
        .en  (step),
        .num ({ay_sq, {F{1'b0}}}),
        .den (len),
        .quo (quy)
    );

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            sp1_ux_reg <= sx_p ? -$signed({1'b0, qux[UQ_W-1:0]}) : $signed({1'b0, qux[UQ_W-1:0]});
            sp1_uy_reg <= sy_p ? -$signed({1'b0, quy[UQ_W-1:0]}) : $signed({1'b0, quy[UQ_W-1:0]});
        end
    end

    cir_delay #(.W(2 * UX_W), .D(S_A + 1 - S_P)) u_dly_u (
        .clk (clk),
        .en  (step),
        .d   ({sp1_ux_reg, sp1_uy_reg}),
        .q   ({ux_t2, uy_t2})
    );

    // ---------------- tangential impulse jt ----------------
    logic signed [RV_W-1:0]  rx_p1, ry_p1;
    logic signed [DP_W-1:0]  sp2_dpx_next, sp2_dpy_next;
    logic signed [DP_W-1:0]  sp2_dpx_reg, sp2_dpy_reg;
    logic signed [D_W-1:0]   sp3_d_reg;
    logic        [D_W-1:0]   sp4_dmag_reg;
    logic                    sp4_dpos_reg;
    logic        [IMS_W-1:0] ims_d;
    logic        [D_W-1:0]   qd;
    logic                    dpos_q;
    logic        [J_W-1:0]   qd_sat;
    logic signed [JT_W-1:0]  sa_jt_reg;
    logic                    sa_jnz_reg;

    cir_delay #(.W(2 * RV_W), .D(S_P)) u_dly_rp (
        .clk (clk),
        .en  (step),
        .d   ({s1_rx_reg, s1_ry_reg}),
        .q   ({rx_p1, ry_p1})
    );

    assign sp2_dpx_next = rx_p1 * sp1_ux_reg;
    assign sp2_dpy_next = ry_p1 * sp1_uy_reg;

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            sp2_dpx_reg  <= sp2_dpx_next;
            sp2_dpy_reg  <= sp2_dpy_next;
            sp3_d_reg    <= D_W'(sp2_dpx_reg) + D_W'(sp2_dpy_reg);
            sp4_dmag_reg <= sp3_d_reg[D_W-1] ? D_W'(-sp3_d_reg) : D_W'(sp3_d_reg);
            sp4_dpos_reg <= !sp3_d_reg[D_W-1] && (sp3_d_reg != '0);
        end
    end

    cir_delay #(.W(IMS_W), .D(S_D - 1)) u_dly_imsd (
        .clk (clk),
        .en  (step),
        .d   (s1_ims_reg),
        .q   (ims_d)
    );

    cir_div #(.NW(D_W), .DW(IMS_W)) u_div_jt (
        .clk (clk),
        .en  (step),
        .num (sp4_dmag_reg),
        .den (ims_d),
        .quo (qd)
    );

    cir_delay #(.W(1), .D(D_W)) u_dly_dpos (
        .clk (clk),
        .en  (step),
        .d   (sp4_dpos_reg),
        .q   (dpos_q)
    );

    assign qd_sat = (qd > D_W'(cir_pkg::J_MAX)) ? cir_pkg::J_MAX : qd[J_W-1:0];

    // jt opposes the relative tangential velocity
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            sa_jt_reg  <= dpos_q ? -$signed({1'b0, qd_sat}) : $signed({1'b0, qd_sat});
            sa_jnz_reg <= (qd_sat != '0);
        end
    end

    // ---------------- combine ----------------
    logic signed [NRM_W-1:0] nx_a, ny_a;
    logic        [CO_W-1:0]  mus_a, mud_a;
    logic                    zero_t3, sep_t3;
    logic signed [JT_W-1:0]  j_s;

    cir_delay #(.W(2 * NRM_W + 2 * CO_W), .D(S_A - 1)) u_dly_na (
        .clk (clk),
        .en  (step),
        .d   ({s1_nx_reg, s1_ny_reg, s1_mus_reg, s1_mud_reg}),
        .q   ({nx_a, ny_a, mus_a, mud_a})
    );

    cir_delay #(.W(1), .D(S_A + 2)) u_dly_zero (
        .clk (clk),
        .en  (step),
        .d   (s1_zero_reg),
        .q   (zero_t3)
    );

    cir_delay #(.W(1), .D(S_A - 1)) u_dly_sep (
        .clk (clk),
        .en  (step),
        .d   (s4_sep_reg),
        .q   (sep_t3)
    );

    assign j_s = $signed({1'b0, j_a});

    // t1: products on j
    logic signed [NJP_W-1:0] t1_njx_next, t1_njy_next;
    logic signed [NJP_W-1:0] t1_njx_reg, t1_njy_reg;
    logic        [JM_W-1:0]  t1_jmus_reg, t1_jmud_reg;
    logic signed [JT_W-1:0]  t1_jt_reg;
    logic                    t1_fric_reg;

    assign t1_njx_next = nx_a * j_s;
    assign t1_njy_next = ny_a * j_s;

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            t1_njx_reg  <= t1_njx_next;
            t1_njy_reg  <= t1_njy_next;
            t1_jmus_reg <= JM_W'(j_a) * JM_W'(mus_a);
            t1_jmud_reg <= JM_W'(j_a) * JM_W'(mud_a);
            t1_jt_reg   <= sa_jt_reg;
            t1_fric_reg <= len_nz_a && sa_jnz_reg;
        end
    end

    // t2: static or dynamic friction, normal impulse rounded
    logic [LIM_W-1:0]       t1_lim;
    logic [J_W-1:0]         t1_jtmag;
    logic [JM_W-F:0]        t1_fr;
    logic [J_W-1:0]         t1_f;
    logic                   t1_stat;
    logic signed [INJ_W-1:0] t2_inx_reg, t2_iny_reg;
    logic signed [JT_W-1:0] t2_c_reg;
    logic                   t2_fric_reg;

    assign t1_lim   = LIM_W'(((JM_W + 1)'(t1_jmus_reg) + (JM_W + 1)'((1 << F) - 1)) >> F);
    assign t1_jtmag = t1_jt_reg[JT_W-1] ? J_W'(-t1_jt_reg) : J_W'(t1_jt_reg);
    assign t1_stat  = CMP_W'(t1_jtmag) < CMP_W'(t1_lim);
    assign t1_fr    = (JM_W - F + 1)'(((JM_W + 1)'(t1_jmud_reg) + (JM_W + 1)'(HALF)) >> F);
    assign t1_f     = (t1_fr > (JM_W - F + 1)'(cir_pkg::J_MAX)) ? cir_pkg::J_MAX
                                                                 : t1_fr[J_W-1:0];

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            t2_inx_reg  <= INJ_W'(rnd(RND_W'(t1_njx_reg)));
            t2_iny_reg  <= INJ_W'(rnd(RND_W'(t1_njy_reg)));
            t2_c_reg    <= t1_stat ? t1_jt_reg : -$signed({1'b0, t1_f});
            t2_fric_reg <= t1_fric_reg;
        end
    end

    // t3: friction impulse products
    logic signed [PF_W-1:0]  t3_pfx_next, t3_pfy_next;
    logic signed [PF_W-1:0]  t3_pfx_reg, t3_pfy_reg;
    logic signed [INJ_W-1:0] t3_inx_reg, t3_iny_reg;
    logic                    t3_fric_reg;

    assign t3_pfx_next = ux_t2 * t2_c_reg;
    assign t3_pfy_next = uy_t2 * t2_c_reg;

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            t3_pfx_reg  <= t3_pfx_next;
            t3_pfy_reg  <= t3_pfy_next;
            t3_inx_reg  <= t2_inx_reg;
            t3_iny_reg  <= t2_iny_reg;
            t3_fric_reg <= t2_fric_reg;
        end
    end

    // t4: sum, saturate, output register
    logic signed [S_W-1:0]   t3_sx, t3_sy;
    logic signed [OUT_W-1:0] t3_satx, t3_saty;
    cir_pkg::action_t        t3_act;
    cir_pkg::action_t        act_reg;
    logic signed [OUT_W-1:0] imp_x_reg, imp_y_reg;

    assign t3_sx = S_W'(t3_inx_reg)
                 + (t3_fric_reg ? S_W'(PFR_W'(rnd(RND_W'(t3_pfx_reg)))) : '0);
    assign t3_sy = S_W'(t3_iny_reg)
                 + (t3_fric_reg ? S_W'(PFR_W'(rnd(RND_W'(t3_pfy_reg)))) : '0);

    always_comb
    begin
        if (!t3_sx[S_W-1] && (t3_sx[S_W-2:OUT_W-1] != '0))
        begin
            t3_satx = {1'b0, {(OUT_W-1){1'b1}}};
        end
        else if (t3_sx[S_W-1] && (t3_sx[S_W-2:OUT_W-1] != '1))
        begin
            t3_satx = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else
        begin
            t3_satx = t3_sx[OUT_W-1:0];
        end

        if (!t3_sy[S_W-1] && (t3_sy[S_W-2:OUT_W-1] != '0))
        begin
            t3_saty = {1'b0, {(OUT_W-1){1'b1}}};
        end
        else if (t3_sy[S_W-1] && (t3_sy[S_W-2:OUT_W-1] != '1))
        begin
            t3_saty = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else
        begin
            t3_saty = t3_sy[OUT_W-1:0];
        end

        if (zero_t3)
        begin
            t3_act = cir_pkg::ACT_ZERO;
        end
        else if (sep_t3)
        begin
            t3_act = cir_pkg::ACT_NONE;
        end
        else if (t3_fric_reg)
        begin
            t3_act = cir_pkg::ACT_FRICTION;
        end
        else
        begin
            t3_act = cir_pkg::ACT_NORMAL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            act_reg   <= t3_act;
            imp_x_reg <= (zero_t3 || sep_t3) ? '0 : t3_satx;
            imp_y_reg <= (zero_t3 || sep_t3) ? '0 : t3_saty;
        end
    end

    assign action    = act_reg;
    assign impulse_x = imp_x_reg;
    assign impulse_y = imp_y_reg;

endmodule

### src/cir_check.sv
module cir_check (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              item_valid,
    input logic                              item_ready,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic        [1:0]                 action,
    input logic signed [cir_pkg::OUT_W-1:0]  impulse_x,
    input logic signed [cir_pkg::OUT_W-1:0]  impulse_y
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(action) && $stable(impulse_x) && $stable(impulse_y))
        else $error("result changed while stalled");

    // no contact and zero-mass cases carry no impulse
    a_zero_imp: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (action == cir_pkg::ACT_NONE || action == cir_pkg::ACT_ZERO) |->
            impulse_x == '0 && impulse_y == '0)
        else $error("impulse on a no-op result");

    // input side only backs up when the output is blocked
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (!result_valid || result_ready) |-> item_ready)
        else $error("input stalled with output free");

    // a transfer on the input is never dropped by a ready that falls on its own
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |-> result_valid && !result_ready)
        else $error("input refused without output stall");

endmodule

bind contact_impulse_with_friction cir_check u_cir_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .action       (action),
    .impulse_x    (impulse_x),
    .impulse_y    (impulse_y)
);

### tb/tb_top.sv
module tb_top;

    // Contact fields as driven onto the ports
    typedef struct {
        logic signed [cir_pkg::VEL_W-1:0] vax, vay, vbx, vby;
        logic        [cir_pkg::IM_W-1:0]  ima, imb;
        logic signed [cir_pkg::NRM_W-1:0] nx, ny;
        logic        [cir_pkg::CO_W-1:0]  e, mus, mud;
    } contact_t;

    // One resolved contact
    typedef struct {
        cir_pkg::action_t                 act;
        logic signed [cir_pkg::OUT_W-1:0] ix, iy;
    } impulse_t;

    localparam int FB = 16;
    localparam int LATENCY = 116 + 2 * FB;
    localparam longint JLIM = 64'h3F_FFFF_FFFF;
    localparam longint ONE = 64'sd1 <<< FB;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    logic signed [cir_pkg::VEL_W-1:0] vel_a_x, vel_a_y, vel_b_x, vel_b_y;
    logic [cir_pkg::IM_W-1:0] inv_mass_a, inv_mass_b;
    logic signed [cir_pkg::NRM_W-1:0] normal_x, normal_y;
    logic [cir_pkg::CO_W-1:0] bounce, stick_coeff, slide_coeff;
    logic result_valid;
    logic result_ready;
    logic [1:0] action;
    logic signed [cir_pkg::OUT_W-1:0] impulse_x, impulse_y;

    impulse_t pending_impulses[$];
    int errors;
    int sent;
    int received;
    int act_seen[4];
    bit stall_on;

    contact_impulse_with_friction #(.FRAC_BITS(FB)) u_top (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready),
        .vel_a_x(vel_a_x), .vel_a_y(vel_a_y), .vel_b_x(vel_b_x), .vel_b_y(vel_b_y),
        .inv_mass_a(inv_mass_a), .inv_mass_b(inv_mass_b),
        .normal_x(normal_x), .normal_y(normal_y),
        .bounce(bounce), .stick_coeff(stick_coeff), .slide_coeff(slide_coeff),
        .result_valid(result_valid), .result_ready(result_ready),
        .action(action), .impulse_x(impulse_x), .impulse_y(impulse_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous ceiling: ~2000 contacts, each worst case long gap plus long stall
    initial
    begin
        #8000000;
        $display("tb_top failed");
        $finish;
    end

    // ---------------- fixed-point helpers ----------------

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Shift right by FB, rounding half away from zero
    function automatic longint rnd_shift(longint v);
        longint m;
        m = (abs64(v) + (ONE >>> 1)) >>> FB;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [cir_pkg::OUT_W-1:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[cir_pkg::OUT_W-1:0];
    endfunction

    // Resolve one contact: normal impulse plus Coulomb friction along the tangent
    function automatic impulse_t resolve_contact(contact_t c);
        impulse_t r;
        longint rx, ry, vn, vnq, j, tx, ty, ux, uy, d, jt, ix, iy, f, nx, ny;
        longint unsigned ims, q, ax, ay, len, lim;
        cir_pkg::action_t act;
        r.act = cir_pkg::ACT_NONE;
        r.ix = '0;
        r.iy = '0;
        ims = longint'(c.ima) + longint'(c.imb);
        if (ims == 0)
        begin
            r.act = cir_pkg::ACT_ZERO;
            return r;
        end
        nx = c.nx;
        ny = c.ny;
        rx = longint'(c.vbx) - longint'(c.vax);
        ry = longint'(c.vby) - longint'(c.vay);
        vn = rx * nx + ry * ny;
        if (vn > 0)
            return r;
        vnq = rnd_shift(vn);
        q = (longint'(abs64(vnq)) * longint'(ONE + longint'(c.e))) / ims;
        j = q > JLIM ? JLIM : longint'(q);
        ix = rnd_shift(nx * j);
        iy = rnd_shift(ny * j);
        act = cir_pkg::ACT_NORMAL;
        tx = rx - rnd_shift(nx * vnq);
        ty = ry - rnd_shift(ny * vnq);
        ax = abs64(tx);
        ay = abs64(ty);
        while (ax >= (64'd1 << 30) || ay >= (64'd1 << 30))
        begin
            ax >>= 1;
            ay >>= 1;
        end
        len = int_sqrt(ax * ax + ay * ay);
        if (len != 0)
        begin
            ux = longint'((ax << FB) / len);
            uy = longint'((ay << FB) / len);
            if (tx < 0)
                ux = -ux;
            if (ty < 0)
                uy = -uy;
            d = rx * ux + ry * uy;
            q = longint'(abs64(d)) / ims;
            if (q > JLIM)
                q = JLIM;
            jt = d > 0 ? -longint'(q) : longint'(q);
            if (jt != 0)
            begin
                lim = (longint'(j * longint'(c.mus)) + ONE - 1) >> FB;
                act = cir_pkg::ACT_FRICTION;
                if (longint'(abs64(jt)) < lim)
                begin
                    ix += rnd_shift(ux * jt);
                    iy += rnd_shift(uy * jt);
                end
                else
                begin
                    f = rnd_shift(j * longint'(c.mud));
                    if (f > JLIM)
                        f = JLIM;
                    ix -= rnd_shift(ux * f);
                    iy -= rnd_shift(uy * f);
                end
            end
        end
        r.act = act;
        r.ix = clamp32(ix);
        r.iy = clamp32(iy);
        return r;
    endfunction

    // ---------------- gaps ----------------

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // ---------------- send one contact ----------------

    task automatic send_contact(contact_t c);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            item_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        item_valid <= 1'b1;
        vel_a_x <= c.vax;
        vel_a_y <= c.vay;
        vel_b_x <= c.vbx;
        vel_b_y <= c.vby;
        inv_mass_a <= c.ima;
        inv_mass_b <= c.imb;
        normal_x <= c.nx;
        normal_y <= c.ny;
        bounce <= c.e;
        stick_coeff <= c.mus;
        slide_coeff <= c.mud;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        // transfer happened at this edge
        pending_impulses.push_back(resolve_contact(c));
        sent++;
    endtask

    // Receiver: random back-pressure, with quiet stretches of none
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if ($urandom_range(199) == 0)
                stall_on <= ~stall_on;
            if (!stall_on)
                result_ready <= 1'b1;
            else if ($urandom_range(99) < 8)
                result_ready <= 1'b0; // occasional forced hold
            else
                result_ready <= ($urandom_range(99) < 65);
        end
    end

    // Result checker: compare each transfer with the oldest prediction
    always @(posedge clk)
    begin
        impulse_t x;
        if (rst_n && result_valid && result_ready)
        begin
            received++;
            if (pending_impulses.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result act=%0d ix=%0d iy=%0d",
                         $time, action, impulse_x, impulse_y);
            end
            else
            begin
                x = pending_impulses.pop_front();
                act_seen[action]++;
                if (action !== x.act)
                begin
                    errors++;
                    $display("%0t: action expected %0d got %0d", $time, x.act, action);
                end
                if (impulse_x !== x.ix)
                begin
                    errors++;
                    $display("%0t: impulse_x expected %0d got %0d", $time, x.ix, impulse_x);
                end
                if (impulse_y !== x.iy)
                begin
                    errors++;
                    $display("%0t: impulse_y expected %0d got %0d", $time, x.iy, impulse_y);
                end
            end
        end
    end

    // ---------------- contact builders ----------------

    function automatic logic [31:0] rand_vel();
        case ($urandom_range(4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
        endcase
    endfunction

    function automatic logic [30:0] rand_im();
        case ($urandom_range(5))
            0: return '0;
            1: return 31'($urandom());
            2: return 31'h7FFF_FFFF;
            3: return 31'($urandom_range(1));
            default: return 31'($urandom_range(4 << 16));
        endcase
    endfunction

    function automatic logic [17:0] rand_nrm();
        case ($urandom_range(3))
            0: return 18'($urandom());
            1: return $urandom_range(1) ? 18'sd65536 : -18'sd65536;
            default: return 18'($signed($urandom_range(131072)) - 65536);
        endcase
    endfunction

    function automatic logic [17:0] rand_co();
        return $urandom_range(3) == 0 ? 18'($urandom()) : 18'($urandom_range(131072));
    endfunction

    function automatic contact_t rand_contact();
        contact_t c;
        c.vax = rand_vel();
        c.vay = rand_vel();
        c.vbx = rand_vel();
        c.vby = rand_vel();
        c.ima = rand_im();
        c.imb = $urandom_range(19) == 0 ? 31'd0 : rand_im();
        if ($urandom_range(19) == 0)
            c.ima = '0;
        c.nx = rand_nrm();
        c.ny = rand_nrm();
        c.e = rand_co();
        c.mus = rand_co();
        c.mud = rand_co();
        return c;
    endfunction

    // Approaching contact with a unit-ish normal, so friction paths get exercised
    function automatic contact_t approach_contact();
        contact_t c;
        c = rand_contact();
        c.ima = 31'($urandom_range(2 << 16, 1));
        c.imb = 31'($urandom_range(2 << 16));
        case ($urandom_range(3))
            0: begin c.nx = 18'sd65536; c.ny = '0; end
            1: begin c.nx = '0; c.ny = -18'sd65536; end
            2: begin c.nx = 18'sd46341; c.ny = 18'sd46341; end
            default: begin c.nx = -18'sd39322; c.ny = 18'sd52429; end
        endcase
        c.vax = 32'($signed($urandom_range(20 << 16)) - (10 << 16));
        c.vay = 32'($signed($urandom_range(20 << 16)) - (10 << 16));
        c.vbx = c.vax - 32'($signed(c.nx) * int'($urandom_range(8))) +
                32'($signed($urandom_range(4 << 16)) - (2 << 16));
        c.vby = c.vay - 32'($signed(c.ny) * int'($urandom_range(8))) +
                32'($signed($urandom_range(4 << 16)) - (2 << 16));
        c.e = 18'($urandom_range(65536));
        c.mus = 18'($urandom_range(131072));
        c.mud = 18'($urandom_range(c.mus));
        return c;
    endfunction

    function automatic contact_t base_contact();
        contact_t c;
        c.vax = '0; c.vay = '0; c.vbx = '0; c.vby = '0;
        c.ima = 31'd65536; c.imb = 31'd65536;
        c.nx = 18'sd65536; c.ny = '0;
        c.e = 18'd32768; c.mus = 18'd32768; c.mud = 18'd16384;
        return c;
    endfunction

    // ---------------- tests ----------------

    task automatic test_special_cases();
        contact_t c;
        // both inverse masses zero
        c = base_contact(); c.ima = '0; c.imb = '0; c.vbx = -32'sd65536;
        send_contact(c);
        // separating along the normal
        c = base_contact(); c.vbx = 32'sd65536;
        send_contact(c);
        // head-on, no tangent: normal impulse only
        c = base_contact(); c.vbx = -32'sd131072;
        send_contact(c);
        // zero normal
        c = base_contact(); c.nx = '0; c.vbx = 32'sd100000; c.vby = 32'sd5000;
        send_contact(c);
        // sticking friction: small slip, high static coeff
        c = base_contact(); c.vbx = -32'sd131072; c.vby = 32'sd100;
        c.mus = 18'd131072;
        send_contact(c);
        // sliding friction: big slip, low static coeff
        c = base_contact(); c.vbx = -32'sd65536; c.vby = 32'sd500000;
        c.mus = 18'd0; c.mud = 18'd131072;
        send_contact(c);
        // tiny slip that rounds jt to zero
        c = base_contact(); c.vbx = -32'sd65536; c.vby = 32'sd1;
        c.ima = 31'h7FFF_FFFF; c.imb = 31'h7FFF_FFFF;
        send_contact(c);
    endtask

    task automatic test_field_extremes();
        contact_t c;
        c = base_contact();
        c.vax = 32'sh7FFF_FFFF; c.vay = 32'sh7FFF_FFFF;
        c.vbx = 32'sh8000_0000; c.vby = 32'sh8000_0000;
        c.ima = 31'd1; c.imb = '0; c.nx = 18'sd65536; c.ny = 18'sd65536;
        c.e = 18'd131072; c.mus = 18'd131072; c.mud = 18'd131072;
        send_contact(c);
        c.ny = -18'sd65536;
        send_contact(c);
        c.nx = -18'sd65536; c.ny = 18'sd65536; c.vax = 32'sh8000_0000;
        send_contact(c);
        // out-of-range raw bits on the normal and coefficient fields
        c.nx = 18'h3FFFF; c.ny = 18'h20000; c.e = 18'h3FFFF; c.mus = 18'h3FFFF;
        c.mud = 18'h3FFFF; c.ima = 31'h7FFF_FFFF; c.imb = 31'h7FFF_FFFF;
        c.vax = '1; c.vay = '0; c.vbx = 32'sh8000_0000; c.vby = 32'sh7FFF_FFFF;
        send_contact(c);
        c.nx = 18'h1FFFF; c.ny = 18'h1FFFF; c.vbx = 32'sh8000_0000; c.vax = '0;
        c.ima = 31'd1; c.imb = '0;
        send_contact(c);
        c.mus = '0; c.mud = '0; c.e = '0;
        send_contact(c);
    endtask

    task automatic test_random_mix(int n);
        for (int i = 0; i < n; i++)
            send_contact($urandom_range(99) < 65 ? approach_contact() : rand_contact());
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (pending_impulses.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    // ---------------- main sequence ----------------

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        errors = 0;
        sent = 0;
        received = 0;
        vel_a_x = '0; vel_a_y = '0; vel_b_x = '0; vel_b_y = '0;
        inv_mass_a = '0; inv_mass_b = '0;
        normal_x = '0; normal_y = '0;
        bounce = '0; stick_coeff = '0; slide_coeff = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_field_extremes();
        test_random_mix(1900);
        drain();

        $display("Resolved %0d contacts (%0d results): none %0d, zero %0d, normal %0d, friction %0d",
                 sent, received, act_seen[0], act_seen[1], act_seen[2], act_seen[3]);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

### filelist.f
src/cir_pkg.sv
src/cir_delay.sv
src/cir_div.sv
src/cir_sqrt.sv
src/contact_impulse_with_friction.sv
src/cir_check.sv
tb/tb_top.sv
